// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CP     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_OPEN      = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_END_ESC      = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd4;
    localparam logic [3:0] ERR_HEX_SHORT    = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
    localparam logic [3:0] ERR_LONE_HIGH    = 4'd8;
    localparam logic [3:0] ERR_BAD_PAIR     = 4'd9;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       string_done;
        logic [3:0] error_code;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] data;
        logic        done;
        logic [3:0]  err;
    } t_cmd;

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  jsu_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output jsu_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX     = 3'd3;
    localparam logic [2:0] PH_WANT_BS = 3'd4;
    localparam logic [2:0] PH_WANT_U  = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    logic        r_low, n_low;

    logic        accept;
    logic [7:0]  c;
    logic        fin;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] acc_next;
    logic        do_status;
    logic        st_done;
    logic [3:0]  st_err;
    logic        do_emit;
    logic [1:0]  em_kind;
    logic [20:0] em_data;

    assign accept   = i_valid && !i_full;
    assign c        = i_item.in_byte;
    assign fin      = i_item.text_end;
    assign acc_next = {r_acc[11:0], hex_d};

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_d = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_d = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_hs      = r_hs;
        n_low     = r_low;
        do_status = 1'b0;
        st_done   = 1'b0;
        st_err    = jsu_pkg::ERR_NONE;
        do_emit   = 1'b0;
        em_kind   = jsu_pkg::KIND_BYTE;
        em_data   = '0;
        if (accept) begin
            unique case (r_phase)
                PH_BODY: begin
                    if (fin) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_UNTERMINATED;
                    end else if (c == 8'h22) begin
                        do_status = 1'b1;
                        st_done   = 1'b1;
                    end else if (c[7:5] == 3'b000) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_CONTROL;
                    end else if (c == 8'h5C) begin
                        n_phase = PH_ESC;
                    end else begin
                        do_emit = 1'b1;
                        em_data = {13'd0, c};
                    end
                end
                PH_ESC: begin
                    if (fin) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_END_ESC;
                    end else begin
                        n_phase = PH_BODY;
                        do_emit = 1'b1;
                        case (c)
                            8'h22, 8'h5C, 8'h2F: em_data = {13'd0, c};
                            8'h62: em_data = 21'h08;
                            8'h66: em_data = 21'h0C;
                            8'h6E: em_data = 21'h0A;
                            8'h72: em_data = 21'h0D;
                            8'h74: em_data = 21'h09;
                            8'h75: begin
                                do_emit = 1'b0;
                                n_phase = PH_HEX;
                                n_acc   = '0;
                                n_cnt   = '0;
                                n_low   = 1'b0;
                            end
                            default: begin
                                do_emit   = 1'b0;
                                do_status = 1'b1;
                                st_err    = jsu_pkg::ERR_BAD_ESC;
                            end
                        endcase
                    end
                end
                PH_HEX: begin
                    if (fin) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_HEX_SHORT;
                    end else if (!hex_ok) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_BAD_HEX;
                    end else begin
                        n_acc = acc_next;
                        if (r_cnt != 2'd3) begin
                            n_cnt = r_cnt + 2'd1;
                        end else begin
                            n_cnt = '0;
                            if (!r_low) begin
                                if (acc_next < 16'hD800 || acc_next > 16'hDFFF) begin
                                    do_emit = 1'b1;
                                    em_kind = jsu_pkg::KIND_CP;
                                    em_data = {5'd0, acc_next};
                                    n_phase = PH_BODY;
                                end else if (acc_next > 16'hDBFF) begin
                                    do_status = 1'b1;
                                    st_err    = jsu_pkg::ERR_LONE_LOW;
                                end else begin
                                    n_hs    = acc_next[9:0];
                                    n_phase = PH_WANT_BS;
                                end
                            end else begin
                                if (acc_next < 16'hDC00 || acc_next > 16'hDFFF) begin
                                    do_status = 1'b1;
                                    st_err    = jsu_pkg::ERR_BAD_PAIR;
                                end else begin
                                    n_low   = 1'b0;
                                    do_emit = 1'b1;
                                    em_kind = jsu_pkg::KIND_CP;
                                    em_data = 21'h10000 + {1'b0, r_hs, acc_next[9:0]};
                                    n_phase = PH_BODY;
                                end
                            end
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (fin || c != 8'h5C) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_LONE_HIGH;
                    end else begin
                        n_phase = PH_WANT_U;
                    end
                end
                PH_WANT_U: begin
                    if (fin || c != 8'h75) begin
                        do_status = 1'b1;
                        st_err    = jsu_pkg::ERR_LONE_HIGH;
                    end else begin
                        n_phase = PH_HEX;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_low   = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_hs    = '0;
                    n_low   = 1'b0;
                    if (!fin) begin
                        if (c == 8'h22) begin
                            n_phase = PH_BODY;
                        end else begin
                            do_status = 1'b1;
                            st_err    = jsu_pkg::ERR_NO_OPEN;
                        end
                    end
                end
            endcase
            if (do_status) begin
                n_phase = PH_IDLE;
                n_acc   = '0;
                n_cnt   = '0;
                n_hs    = '0;
                n_low   = 1'b0;
            end
        end
    end

    assign o_push     = do_status || do_emit;
    assign o_cmd.kind = do_status ? jsu_pkg::KIND_STATUS : em_kind;
    assign o_cmd.data = do_status ? 21'd0 : em_data;
    assign o_cmd.done = st_done;
    assign o_cmd.err  = st_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
            r_low   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
            r_low   <= n_low;
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output jsu_pkg::t_cmd o_cmd
);

    jsu_pkg::t_cmd           r_mem [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [jsu_pkg::Q_AW:0]   r_count;
    logic                     do_push, do_pop;

    assign o_full  = (r_count == (jsu_pkg::Q_AW+1)'(jsu_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + jsu_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + jsu_pkg::Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (jsu_pkg::Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (jsu_pkg::Q_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  jsu_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output jsu_pkg::t_out_item o_item
);

    logic             r_have;
    logic [3:0][7:0]  r_bytes;
    logic [1:0]       r_n, r_idx;
    logic             r_stat, r_done;
    logic [3:0]       r_err;

    logic [3:0][7:0]  enc_bytes;
    logic [1:0]       enc_n;
    logic [20:0]      cp;
    logic             last, take, load;

    assign cp = i_q_cmd.data;

    always_comb begin
        enc_bytes = '0;
        enc_n     = 2'd0;
        case (i_q_cmd.kind)
            jsu_pkg::KIND_BYTE: begin
                enc_bytes[0] = cp[7:0];
            end
            jsu_pkg::KIND_CP: begin
                if (cp <= 21'h7F) begin
                    enc_bytes[0] = cp[7:0];
                end else if (cp <= 21'h7FF) begin
                    enc_bytes[0] = {3'b110, cp[10:6]};
                    enc_bytes[1] = {2'b10, cp[5:0]};
                    enc_n        = 2'd1;
                end else if (cp <= 21'hFFFF) begin
                    enc_bytes[0] = {4'b1110, cp[15:12]};
                    enc_bytes[1] = {2'b10, cp[11:6]};
                    enc_bytes[2] = {2'b10, cp[5:0]};
                    enc_n        = 2'd2;
                end else begin
                    enc_bytes[0] = {5'b11110, cp[20:18]};
                    enc_bytes[1] = {2'b10, cp[17:12]};
                    enc_bytes[2] = {2'b10, cp[11:6]};
                    enc_bytes[3] = {2'b10, cp[5:0]};
                    enc_n        = 2'd3;
                end
            end
            default: begin
                enc_bytes = '0;
            end
        endcase
    end

    assign last    = (r_idx == r_n);
    assign take    = r_have && !i_stall;
    assign load    = i_q_valid && (!r_have || (take && last));
    assign o_q_pop = load;

    assign o_valid            = r_have;
    assign o_item.out_byte    = r_stat ? 8'd0 : r_bytes[r_idx];
    assign o_item.byte_valid  = !r_stat;
    assign o_item.last_of_run = last;
    assign o_item.string_done = r_done;
    assign o_item.error_code  = r_err;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= enc_bytes;
            r_n     <= enc_n;
            r_stat  <= (i_q_cmd.kind == jsu_pkg::KIND_STATUS);
            r_done  <= i_q_cmd.done;
            r_err   <= i_q_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_have <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_have <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/json_string_unescape_utf8_top.sv =====
// The first result of an accepted item is written into the queue and then loaded into
// the output register; a busy output stage holds it in the queue.
// Throughput: one input item per cycle while the queue is not full; each result takes
// one output cycle unless stalled; UTF-8 bytes go out in turn via a four-entry queue.
// Reset: synchronous, active low; returns to waiting for an opening quote and empties
// the queue and the output stage.
module json_string_unescape_utf8_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_item
);

    logic          push, full, pop, q_valid;
    jsu_pkg::t_cmd f_cmd, q_cmd;

    assign o_in_stall = full;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule

// ===== rtl/jsu_checker.sv =====
module jsu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input jsu_pkg::t_out_item o_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled item changed");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |->
            o_out_item.last_of_run && o_out_item.out_byte == 8'd0 &&
            (o_out_item.string_done != (o_out_item.error_code != jsu_pkg::ERR_NONE)))
        else $error("malformed status item");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.byte_valid |->
            !o_out_item.string_done && o_out_item.error_code == jsu_pkg::ERR_NONE)
        else $error("byte item carries status");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.error_code <= jsu_pkg::ERR_UNTERMINATED)
        else $error("error code out of range");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);
